// ===== rtl/pcbc_pkg.sv =====
// Shared constants and types for the point cloud bounds/centroid block.
// No dependencies; compiled first.
package pcbc_pkg;

  localparam int unsigned MAX_POINTS  = 1048576;
  localparam int unsigned COORD_BITS  = 32;
  localparam int unsigned AXES        = 3;
  localparam int unsigned CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int unsigned SUM_W       = COORD_BITS + $clog2(MAX_POINTS);
  localparam int unsigned STEP_W      = $clog2(SUM_W);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COORD_BITS-1:0] MIN_INIT = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic [COORD_BITS-1:0] MAX_INIT = {1'b1, {(COORD_BITS - 1){1'b0}}};
  localparam logic [CNT_W-1:0]      CNT_MAX  = CNT_W'(MAX_POINTS);

  // closed cloud, handed from front to back
  typedef struct packed {
    logic [AXES-1:0][COORD_BITS-1:0] min_v;
    logic [AXES-1:0][COORD_BITS-1:0] max_v;
    logic [AXES-1:0][SUM_W-1:0]      sum_v;
    logic [CNT_W-1:0]                count;
    logic                            drop;
  } pcbc_snap_t;

  // divider lane control
  typedef struct packed {
    logic load;
    logic step;
  } pcbc_div_ctrl_t;

endpackage

// ===== rtl/pcbc_if.sv =====
// Valid/ready channel interfaces for points in and cloud results out.
// Depends on pcbc_pkg.
interface pcbc_point_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pcbc_pkg::COORD_BITS-1:0] point_x;
  logic signed [pcbc_pkg::COORD_BITS-1:0] point_y;
  logic signed [pcbc_pkg::COORD_BITS-1:0] point_z;
  logic                                  last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface pcbc_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pcbc_pkg::COORD_BITS-1:0] min_x;
  logic signed [pcbc_pkg::COORD_BITS-1:0] min_y;
  logic signed [pcbc_pkg::COORD_BITS-1:0] min_z;
  logic signed [pcbc_pkg::COORD_BITS-1:0] max_x;
  logic signed [pcbc_pkg::COORD_BITS-1:0] max_y;
  logic signed [pcbc_pkg::COORD_BITS-1:0] max_z;
  logic signed [pcbc_pkg::COORD_BITS-1:0] centroid_x;
  logic signed [pcbc_pkg::COORD_BITS-1:0] centroid_y;
  logic signed [pcbc_pkg::COORD_BITS-1:0] centroid_z;
  logic [pcbc_pkg::CNT_W-1:0]             point_count;
  logic                                  overflowed;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                  centroid_x, centroid_y, centroid_z, point_count, overflowed,
                  input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                  centroid_x, centroid_y, centroid_z, point_count, overflowed,
                  output ready);
endinterface

// ===== rtl/pcbc_front.sv =====
// Front end: takes point beats, keeps running min/max/sum/count per cloud.
// Depends on pcbc_pkg and pcbc_if; pushes closed clouds into pcbc_fifo.
module pcbc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pcbc_point_if.sink           point_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output pcbc_pkg::pcbc_snap_t snap_o
);

  logic [pcbc_pkg::AXES-1:0][pcbc_pkg::COORD_BITS-1:0] coord;
  logic [pcbc_pkg::AXES-1:0][pcbc_pkg::COORD_BITS-1:0] min_q, min_d, max_q, max_d;
  logic [pcbc_pkg::AXES-1:0][pcbc_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [pcbc_pkg::CNT_W-1:0]                          count_q, count_d;
  logic                                                drop_q, drop_d;
  logic                                                accept, keep;

  assign coord[0] = point_i.point_x;
  assign coord[1] = point_i.point_y;
  assign coord[2] = point_i.point_z;

  // a last point needs a free queue slot; others never stall
  assign point_i.ready = ~(q_full_i & point_i.last_point);
  assign accept        = point_i.valid & point_i.ready;
  assign keep          = count_q < pcbc_pkg::CNT_MAX;

  always_comb begin
    for (int a = 0; a < pcbc_pkg::AXES; a++) begin
      if (keep) begin
        min_d[a] = ($signed(coord[a]) < $signed(min_q[a])) ? coord[a] : min_q[a];
        max_d[a] = ($signed(max_q[a]) < $signed(coord[a])) ? coord[a] : max_q[a];
        sum_d[a] = sum_q[a] + {{(pcbc_pkg::SUM_W - pcbc_pkg::COORD_BITS)
                                {coord[a][pcbc_pkg::COORD_BITS-1]}}, coord[a]};
      end else begin
        min_d[a] = min_q[a];
        max_d[a] = max_q[a];
        sum_d[a] = sum_q[a];
      end
    end
    count_d = keep ? count_q + 1'b1 : count_q;
    drop_d  = drop_q | ~keep;
  end

  assign push_o       = accept & point_i.last_point;
  assign snap_o.min_v = min_d;
  assign snap_o.max_v = max_d;
  assign snap_o.sum_v = sum_d;
  assign snap_o.count = count_d;
  assign snap_o.drop  = drop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= {pcbc_pkg::AXES{pcbc_pkg::MIN_INIT}};
      max_q   <= {pcbc_pkg::AXES{pcbc_pkg::MAX_INIT}};
      sum_q   <= '0;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else if (accept) begin
      if (point_i.last_point) begin
        min_q   <= {pcbc_pkg::AXES{pcbc_pkg::MIN_INIT}};
        max_q   <= {pcbc_pkg::AXES{pcbc_pkg::MAX_INIT}};
        sum_q   <= '0;
        count_q <= '0;
        drop_q  <= 1'b0;
      end else begin
        min_q   <= min_d;
        max_q   <= max_d;
        sum_q   <= sum_d;
        count_q <= count_d;
        drop_q  <= drop_d;
      end
    end
  end

endmodule

// ===== rtl/pcbc_fifo.sv =====
// Two-entry queue of closed clouds between front and back.
// Depends on pcbc_pkg.
module pcbc_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pcbc_pkg::pcbc_snap_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output pcbc_pkg::pcbc_snap_t data_o
);

  pcbc_pkg::pcbc_snap_t                mem_q [pcbc_pkg::QUEUE_DEPTH];
  logic [pcbc_pkg::QPTR_W-1:0]         wr_ptr_q, rd_ptr_q;
  logic [pcbc_pkg::QPTR_W:0]           fill_q;

  assign full_o  = fill_q == (pcbc_pkg::QPTR_W + 1)'(pcbc_pkg::QUEUE_DEPTH);
  assign empty_o = fill_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      fill_q <= fill_q + 1'b1;
      else if (!push_i && pop_i) fill_q <= fill_q - 1'b1;
    end
  end

endmodule

// ===== rtl/pcbc_div.sv =====
// One divider lane: signed sum / unsigned count, truncated, one bit a cycle.
// Depends on pcbc_pkg; stepped by pcbc_back.
module pcbc_div (
  input  logic                           clk_i,
  input  pcbc_pkg::pcbc_div_ctrl_t       ctrl_i,
  input  logic [pcbc_pkg::SUM_W-1:0]     sum_i,
  input  logic [pcbc_pkg::CNT_W-1:0]     divisor_i,
  output logic [pcbc_pkg::COORD_BITS-1:0] quot_o
);

  logic [pcbc_pkg::SUM_W-1:0] quo_q, quo_signed;
  logic [pcbc_pkg::CNT_W-1:0] rem_q;
  logic                       neg_q;
  logic [pcbc_pkg::CNT_W:0]   shifted, diff;
  logic                       ge;

  assign shifted = {rem_q, quo_q[pcbc_pkg::SUM_W-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign ge      = shifted >= {1'b0, divisor_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      neg_q <= sum_i[pcbc_pkg::SUM_W-1];
      quo_q <= sum_i[pcbc_pkg::SUM_W-1] ? -sum_i : sum_i;  // magnitude
      rem_q <= '0;
    end else if (ctrl_i.step) begin
      rem_q <= ge ? diff[pcbc_pkg::CNT_W-1:0] : shifted[pcbc_pkg::CNT_W-1:0];
      quo_q <= {quo_q[pcbc_pkg::SUM_W-2:0], ge};
    end
  end

  assign quo_signed = neg_q ? -quo_q : quo_q;
  assign quot_o     = quo_signed[pcbc_pkg::COORD_BITS-1:0];

endmodule

// ===== rtl/pcbc_back.sv =====
// Back end: pops a closed cloud, runs three divider lanes, holds the result beat.
// Depends on pcbc_pkg, pcbc_if and pcbc_div.
module pcbc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  pcbc_pkg::pcbc_snap_t data_i,
  output logic                 pop_o,
  pcbc_result_if.source        result_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                                          state_q, state_d;
  logic [pcbc_pkg::STEP_W-1:0]                         step_q;
  pcbc_pkg::pcbc_snap_t                                entry_q;
  pcbc_pkg::pcbc_div_ctrl_t                            div_ctrl;
  logic [pcbc_pkg::AXES-1:0][pcbc_pkg::COORD_BITS-1:0] quot, cent_q;
  logic                                                last_step;

  assign pop_o         = (state_q == ST_IDLE) && !empty_i;
  assign div_ctrl.load = pop_o;
  assign div_ctrl.step = state_q == ST_DIV;
  assign last_step     = step_q == pcbc_pkg::STEP_W'(pcbc_pkg::SUM_W - 1);

  for (genvar a = 0; a < pcbc_pkg::AXES; a++) begin : g_lane
    pcbc_div u_div (
      .clk_i     (clk_i),
      .ctrl_i    (div_ctrl),
      .sum_i     (data_i.sum_v[a]),
      .divisor_i (entry_q.count),
      .quot_o    (quot[a])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_DIV;
      ST_DIV:  if (last_step) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (result_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (pop_o)                step_q <= '0;
      else if (div_ctrl.step)   step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) entry_q <= data_i;
    if (state_q == ST_FIN) begin
      // empty cloud cannot reach here, but a zero count gives a zero centroid
      cent_q <= (entry_q.count == '0) ? '0 : quot;
    end
  end

  assign result_o.valid       = state_q == ST_OUT;
  assign result_o.min_x       = entry_q.min_v[0];
  assign result_o.min_y       = entry_q.min_v[1];
  assign result_o.min_z       = entry_q.min_v[2];
  assign result_o.max_x       = entry_q.max_v[0];
  assign result_o.max_y       = entry_q.max_v[1];
  assign result_o.max_z       = entry_q.max_v[2];
  assign result_o.centroid_x  = cent_q[0];
  assign result_o.centroid_y  = cent_q[1];
  assign result_o.centroid_z  = cent_q[2];
  assign result_o.point_count = entry_q.count;
  assign result_o.overflowed  = entry_q.drop;

endmodule

// ===== rtl/point_cloud_bounds_centroid.sv =====
// Point cloud bounds and centroid. Points (signed Q16.16 per axis) stream in
// one beat per cycle; the front end folds each into running per-axis min, max
// and 52-bit sum plus a point count, and never stalls a point that does not
// close a cloud. The beat flagged last_point closes the cloud: its totals are
// pushed into a two-entry queue and the accumulators clear in the same cycle,
// so the next cloud may start at once. The back end pops a cloud and runs three
// restoring divider lanes in parallel, one quotient bit per cycle over the 52-bit
// sum: the pop loads the lanes, they step through every sum bit, the quotients
// are registered and the result beat holds until taken. The divider loop sets the
// cloud rate, as no cloud is popped before the last result is taken; points run
// at one per cycle, and a last point stalls only when two finished clouds already
// sit in the queue. Points beyond MAX_POINTS are dropped and flag overflowed.
// Depends on pcbc_pkg, pcbc_if, pcbc_front, pcbc_fifo, pcbc_div and pcbc_back.
module point_cloud_bounds_centroid (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcbc_point_if.sink    point_i,
  pcbc_result_if.source result_o
);

  pcbc_pkg::pcbc_snap_t push_data, pop_data;
  logic                 push, pop, q_full, q_empty;

  // accumulate and classify beats
  pcbc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (point_i),
    .q_full_i (q_full),
    .push_o   (push),
    .snap_o   (push_data)
  );

  // decouples the streaming front from the slow division
  pcbc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (pop_data)
  );

  // centroid division and result register
  pcbc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (q_empty),
    .data_i   (pop_data),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

// ===== rtl/pcbc_checker.sv =====
// Port-level checks on cloud results, bound to point_cloud_bounds_centroid.
// Depends on pcbc_pkg and pcbc_if.
module pcbc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic signed [pcbc_pkg::COORD_BITS-1:0] min_x_i,
  input logic signed [pcbc_pkg::COORD_BITS-1:0] max_x_i,
  input logic signed [pcbc_pkg::COORD_BITS-1:0] cent_x_i,
  input logic [pcbc_pkg::CNT_W-1:0]             count_i,
  input logic                                  overflowed_i
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(min_x_i) &&
      $stable(cent_x_i) && $stable(count_i) && $stable(overflowed_i))
    else $error("result beat changed while stalled");

  // every cloud has at least one accumulated point and min_x <= max_x
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_i != '0 && min_x_i <= max_x_i)
    else $error("empty or inverted box");

  // drops only happen at capacity
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflowed_i |-> count_i == pcbc_pkg::CNT_MAX)
    else $error("overflow below capacity");

  // truncated mean stays inside the box
  a_cent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> min_x_i <= cent_x_i && cent_x_i <= max_x_i)
    else $error("centroid outside box");

endmodule

bind point_cloud_bounds_centroid pcbc_checker u_pcbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .min_x_i      (result_o.min_x),
  .max_x_i      (result_o.max_x),
  .cent_x_i     (result_o.centroid_x),
  .count_i      (result_o.point_count),
  .overflowed_i (result_o.overflowed)
);

// ===== bench/point_cloud_bounds_centroid_test.sv =====
// Testbench for point_cloud_bounds_centroid: streams point clouds, predicts bounding box,
// centroid, count and overflow per cloud, and compares every result beat field by field.
// Depends on rtl/pcbc_pkg.sv, rtl/pcbc_if.sv and the block's RTL.
`timescale 1ns / 100ps

module point_cloud_bounds_centroid_test;

  localparam int unsigned HOLD_CYCLES = 400;   // long sink hold-off to back up the block
  localparam int unsigned STALL_LIMIT = 5000;  // cycles without any beat before giving up
  localparam int unsigned TAIL_CYCLES = 120;   // settle time after the last result
  localparam int unsigned FEED_DEPTH  = 64;    // how far stimulus runs ahead of the driver

  localparam logic signed [pcbc_pkg::COORD_BITS-1:0] CMIN =
    {1'b1, {(pcbc_pkg::COORD_BITS - 1){1'b0}}};
  localparam logic signed [pcbc_pkg::COORD_BITS-1:0] CMAX =
    {1'b0, {(pcbc_pkg::COORD_BITS - 1){1'b1}}};

  typedef struct packed {
    logic signed [pcbc_pkg::COORD_BITS-1:0] x;
    logic signed [pcbc_pkg::COORD_BITS-1:0] y;
    logic signed [pcbc_pkg::COORD_BITS-1:0] z;
    logic                                   last;
  } cloud_pt_t;

  typedef struct packed {
    logic signed [pcbc_pkg::COORD_BITS-1:0] min_x;
    logic signed [pcbc_pkg::COORD_BITS-1:0] min_y;
    logic signed [pcbc_pkg::COORD_BITS-1:0] min_z;
    logic signed [pcbc_pkg::COORD_BITS-1:0] max_x;
    logic signed [pcbc_pkg::COORD_BITS-1:0] max_y;
    logic signed [pcbc_pkg::COORD_BITS-1:0] max_z;
    logic signed [pcbc_pkg::COORD_BITS-1:0] cen_x;
    logic signed [pcbc_pkg::COORD_BITS-1:0] cen_y;
    logic signed [pcbc_pkg::COORD_BITS-1:0] cen_z;
    logic [pcbc_pkg::CNT_W-1:0]             count;
    logic                                   ovf;
  } cloud_box_t;

  logic clk_i;
  logic rst_ni;

  pcbc_point_if  pt_if ();
  pcbc_result_if res_if ();

  point_cloud_bounds_centroid uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (pt_if),
    .result_o (res_if)
  );

  // Stimulus feed and expected boxes, oldest first.
  cloud_pt_t  points_to_send [$];
  cloud_box_t boxes_due [$];

  // Running cloud state of the predictor.
  logic signed [pcbc_pkg::COORD_BITS-1:0] acc_lo [3];
  logic signed [pcbc_pkg::COORD_BITS-1:0] acc_hi [3];
  longint                                 acc_sum [3];
  int unsigned                            acc_count;
  bit                                     acc_dropped;

  bit          idle_on;      // random idle bursts on both sides
  bit          hold_tog;     // flipped to ask the sink for a long hold-off
  int unsigned mismatches;

  // driver / monitor private state
  cloud_pt_t   on_wire;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned hold_cnt;
  bit          hold_seen;
  int unsigned quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_acc();
    for (int a = 0; a < 3; a++) begin
      acc_lo[a]  = pcbc_pkg::MIN_INIT;   // most positive, first point always wins
      acc_hi[a]  = pcbc_pkg::MAX_INIT;   // most negative
      acc_sum[a] = 0;
    end
    acc_count   = 0;
    acc_dropped = 1'b0;
  endfunction

  // Mean with truncation toward zero; SV signed division already truncates.
  function automatic logic signed [pcbc_pkg::COORD_BITS-1:0] mean_of(longint s);
    if (acc_count == 0) return '0;
    return pcbc_pkg::COORD_BITS'(s / longint'(acc_count));
  endfunction

  // Fold one accepted point into the cloud; on the last point queue the box.
  function automatic void fold_point(cloud_pt_t p);
    logic signed [pcbc_pkg::COORD_BITS-1:0] v [3];
    cloud_box_t b;
    v[0] = p.x;
    v[1] = p.y;
    v[2] = p.z;
    if (acc_count < pcbc_pkg::MAX_POINTS) begin
      for (int a = 0; a < 3; a++) begin
        if (v[a] < acc_lo[a]) acc_lo[a] = v[a];
        if (v[a] > acc_hi[a]) acc_hi[a] = v[a];
        acc_sum[a] += longint'(v[a]);
      end
      acc_count++;
    end else begin
      // cloud full: point is dropped but still closes the cloud if flagged
      acc_dropped = 1'b1;
    end
    if (p.last) begin
      b.min_x = acc_lo[0];
      b.min_y = acc_lo[1];
      b.min_z = acc_lo[2];
      b.max_x = acc_hi[0];
      b.max_y = acc_hi[1];
      b.max_z = acc_hi[2];
      b.cen_x = mean_of(acc_sum[0]);
      b.cen_y = mean_of(acc_sum[1]);
      b.cen_z = mean_of(acc_sum[2]);
      b.count = pcbc_pkg::CNT_W'(acc_count);
      b.ovf   = acc_dropped;
      boxes_due.push_back(b);
      clear_acc();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Point driver: offers queued points, folds each accepted beat into the model
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    bit offer;
    if (!rst_ni) begin
      pt_if.valid      <= 1'b0;
      pt_if.point_x    <= '0;
      pt_if.point_y    <= '0;
      pt_if.point_z    <= '0;
      pt_if.last_point <= 1'b0;
      tx_gap = 0;
      clear_acc();
    end else begin
      offer = pt_if.valid;
      if (pt_if.valid && pt_if.ready) begin
        fold_point(on_wire);
        offer = 1'b0;
      end
      // a beat on offer is never withdrawn; idling only starts between beats
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (idle_on && $urandom_range(15, 0) == 0) begin
          tx_gap = $urandom_range(12, 0);
        end else if (points_to_send.size() > 0) begin
          on_wire = points_to_send.pop_front();
          offer   = 1'b1;
          pt_if.point_x    <= on_wire.x;
          pt_if.point_y    <= on_wire.y;
          pt_if.point_z    <= on_wire.z;
          pt_if.last_point <= on_wire.last;
        end
      end
      pt_if.valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each result beat, drives ready with stalls
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cloud_box_t want;
    bit         take;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_gap    = 0;
      hold_cnt  = 0;
      hold_seen = hold_tog;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (boxes_due.size() == 0) begin
          $error("result beat with no cloud closed");
          mismatches++;
        end else begin
          want = boxes_due.pop_front();
          check_field("min_x", want.min_x, res_if.min_x);
          check_field("min_y", want.min_y, res_if.min_y);
          check_field("min_z", want.min_z, res_if.min_z);
          check_field("max_x", want.max_x, res_if.max_x);
          check_field("max_y", want.max_y, res_if.max_y);
          check_field("max_z", want.max_z, res_if.max_z);
          check_field("centroid_x", want.cen_x, res_if.centroid_x);
          check_field("centroid_y", want.cen_y, res_if.centroid_y);
          check_field("centroid_z", want.cen_z, res_if.centroid_z);
          check_field("point_count", want.count, res_if.point_count);
          check_field("overflowed", want.ovf, res_if.overflowed);
        end
      end
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        hold_cnt  = HOLD_CYCLES;
      end
      take = 1'b0;
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end else if (idle_on && $urandom_range(15, 0) == 0) begin
        rx_gap = $urandom_range(12, 0);
      end else begin
        take = 1'b1;
      end
      res_if.ready <= take;
    end
  end

  // Watchdog: too long without a beat on either side means the block hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Coordinates biased toward the extremes and small values around zero.
  function automatic logic signed [pcbc_pkg::COORD_BITS-1:0] rand_coord();
    case ($urandom_range(9, 0))
      0:       return CMIN;
      1:       return CMAX;
      2:       return pcbc_pkg::COORD_BITS'($signed($urandom_range(64, 0)) - 32);
      3:       return $urandom_range(1, 0) ? '0 : '1;
      default: return pcbc_pkg::COORD_BITS'($urandom);
    endcase
  endfunction

  // Stimulus changes at the falling edge, away from the driver's pops.
  task automatic queue_point(logic signed [pcbc_pkg::COORD_BITS-1:0] x,
                             logic signed [pcbc_pkg::COORD_BITS-1:0] y,
                             logic signed [pcbc_pkg::COORD_BITS-1:0] z, bit last);
    cloud_pt_t p;
    while (points_to_send.size() >= FEED_DEPTH) @(negedge clk_i);
    p.x    = x;
    p.y    = y;
    p.z    = z;
    p.last = last;
    points_to_send.push_back(p);
  endtask

  task automatic queue_cloud(int unsigned npts);
    for (int unsigned i = 0; i < npts; i++)
      queue_point(rand_coord(), rand_coord(), rand_coord(), i == npts - 1);
  endtask

  // Mostly small clouds, now and then a longer one.
  task automatic queue_random_clouds(int unsigned npts);
    int unsigned sent;
    int unsigned k;
    sent = 0;
    while (sent < npts) begin
      k = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 9) : $urandom_range(8, 1);
      queue_cloud(k);
      sent += k;
    end
  endtask

  // Wait until every queued point is taken and every box has come back.
  task automatic drain();
    while (points_to_send.size() != 0 || pt_if.valid || boxes_due.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    // known levels on every input before the first edge
    pt_if.valid      = 1'b0;
    pt_if.point_x    = '0;
    pt_if.point_y    = '0;
    pt_if.point_z    = '0;
    pt_if.last_point = 1'b0;
    res_if.ready     = 1'b0;
    idle_on    = 1'b1;
    hold_tog   = 1'b0;
    mismatches = 0;
    quiet      = 0;
    rst_ni     = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single point at the coordinate extremes: box collapses onto it
    queue_point(CMIN, CMAX, '0, 1'b1);
    // negative sums must truncate toward zero (-1/2 -> 0, -3/2 -> -1)
    queue_point(CMIN, -3, 7, 1'b0);
    queue_point(CMAX, 0, 0, 1'b1);
    // all-max and all-min clouds push the sum to its widest
    queue_point(CMAX, CMAX, CMAX, 1'b0);
    queue_point(CMAX, CMAX, CMAX, 1'b0);
    queue_point(CMAX, CMAX, CMAX, 1'b1);
    queue_point(CMIN, CMIN, CMIN, 1'b0);
    queue_point(CMIN, CMIN, CMIN, 1'b0);
    queue_point(CMIN, CMIN, CMIN, 1'b1);
    // alternating bit patterns
    queue_point(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_ffff, 1'b0);
    queue_point(32'shaaaa_aaaa, 32'sh5555_5555, 32'shffff_0000, 1'b0);
    queue_point(-1, 1, 0, 1'b1);
    // origin alone
    queue_point(0, 0, 0, 1'b1);
    // mixed small values around zero
    queue_point(1, -1, -1, 1'b0);
    queue_point(-1, 1, -2, 1'b0);
    queue_point(-1, -1, 0, 1'b0);
    queue_point(-2, 2, 5, 1'b1);

    queue_random_clouds(600);

    // sender goes quiet until everything is back
    drain();

    // sink holds off while short clouds keep coming: the block's result queue
    // fills and a last point must stall on the input
    hold_tog = ~hold_tog;
    repeat (24) queue_cloud($urandom_range(2, 1));

    queue_random_clouds(300);

    // last stretch at full rate, no idling on either side
    idle_on = 1'b0;
    queue_random_clouds(100);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && boxes_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
